@@ sv/pvm_pkg.sv @@
// Shared types, opcodes and defaults for the Pike-VM regex matcher.
`default_nettype none
package pvm_pkg;

	localparam int PROG_DEPTH_DEF  = 32;
	localparam int NSAVE_DEF       = 8;
	localparam int RANGE_DEPTH_DEF = 64;
	localparam int POS_WIDTH_DEF   = 16;

	localparam logic [1:0] MODE_INSTR = 2'd0;
	localparam logic [1:0] MODE_RANGE = 2'd1;
	localparam logic [1:0] MODE_START = 2'd2;
	localparam logic [1:0] MODE_TEXT  = 2'd3;

	localparam logic [2:0] OP_CHAR   = 3'd0;
	localparam logic [2:0] OP_ANY    = 3'd1;
	localparam logic [2:0] OP_RANGE  = 3'd2;
	localparam logic [2:0] OP_NRANGE = 3'd3;
	localparam logic [2:0] OP_MATCH  = 3'd4;
	localparam logic [2:0] OP_JUMP   = 3'd5;
	localparam logic [2:0] OP_SPLIT  = 3'd6;
	localparam logic [2:0] OP_SAVE   = 3'd7;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] ch;
		logic [5:0] ta;
		logic [4:0] tb;
		logic [4:0] sc;
	} instr_t;

	typedef struct packed {
		logic [7:0] hi;
		logic [7:0] lo;
	} range_t;

endpackage
`default_nettype wire

@@ sv/pvm_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module pvm_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ sv/pike_vm_regex_matcher.sv @@
// Top level of the anchored Pike-VM regex matcher with capture slots.
`default_nettype none
// Anchored Pike-VM matcher. Requests with mode 0 and 1 load the program and
// the range-pair table. A start request seeds a thread at
// instruction 0 and walks its epsilon closure; text requests advance every
// live thread by one byte, byte 0 ends the text. When no thread is left the
// block reports min(NSAVE,8) results (found, end position, one capture slot
// each, last on the final one) and ignores text until the next start.
// Cost: every closure step is a program-memory fetch, and each live thread
// reads its instruction and scans its range pairs one at a time. A typical
// byte is bounded by the single program-memory read port that every thread
// and every closure step goes through; a report gives its results one at a
// time, and no request is taken until the block is idle again.
module pike_vm_regex_matcher #(
	parameter int PROG_DEPTH  = pvm_pkg::PROG_DEPTH_DEF,
	parameter int NSAVE       = pvm_pkg::NSAVE_DEF,
	parameter int RANGE_DEPTH = pvm_pkg::RANGE_DEPTH_DEF,
	parameter int POS_WIDTH   = pvm_pkg::POS_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [5:0]  address,
	input  wire logic [2:0]  opcode,
	input  wire logic [7:0]  char_value,
	input  wire logic [7:0]  range_high,
	input  wire logic [5:0]  target_a,
	input  wire logic [4:0]  target_b,
	input  wire logic [4:0]  slot_or_count,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic        match_found,
	output      logic [15:0] match_end,
	output      logic [2:0]  slot_index,
	output      logic [15:0] slot_value,
	output      logic        last
);

	localparam int PC_W  = $clog2(PROG_DEPTH);
	localparam int CNT_W = $clog2(PROG_DEPTH + 1);
	localparam int SL_W  = $clog2(NSAVE);
	localparam int RI_W  = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;
	localparam int RD_D  = (RANGE_DEPTH > 1) ? RANGE_DEPTH : 2;
	localparam int REP_N = (NSAVE < 8) ? NSAVE : 8;
	localparam int TW    = PC_W + NSAVE * POS_WIDTH;
	localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

	typedef logic [NSAVE-1:0][POS_WIDTH-1:0] slots_t;

	typedef enum logic [3:0] {
		S_IDLE, S_C_FETCH, S_C_EXEC, S_C_POP, S_C_LOAD,
		S_T_READ, S_T_INS, S_T_EVAL, S_R_READ, S_R_CMP, S_ROUND, S_REP
	} state_t;

	state_t state_q;

	// Closure walker registers
	logic [PC_W-1:0]     cpc_q;
	slots_t              cslots_q;
	logic [POS_WIDTH-1:0] cpos_q;
	logic [CNT_W-1:0]    sp_q;
	logic                ret_text_q;
	logic [PROG_DEPTH-1:0] visit_q;

	// Thread list bookkeeping
	logic                sel_q;
	logic [CNT_W-1:0]    n_cur_q;
	logic [CNT_W-1:0]    n_next_q;
	logic [CNT_W-1:0]    t_q;
	logic [PC_W-1:0]     tpc_q;
	slots_t              tslots_q;

	// Range scan
	logic [RI_W-1:0]     ridx_q;
	logic [4:0]          rcnt_q;
	logic [4:0]          rsc_q;
	logic                rneg_q;

	// Run state
	logic                running_q;
	logic                found_q;
	logic [POS_WIDTH-1:0] end_q;
	logic [POS_WIDTH-1:0] position_q;
	logic [POS_WIDTH-1:0] npos_q;
	logic [7:0]          ch_q;
	slots_t              best_q;
	logic [SL_W-1:0]     rep_k_q;

	// Output register
	logic                out_valid_q;
	logic                match_found_q;
	logic [15:0]         match_end_q;
	logic [2:0]          slot_index_q;
	logic [15:0]         slot_value_q;
	logic                last_q;

	// Memory ports
	logic                prog_we;
	logic [PC_W-1:0]     prog_waddr;
	pvm_pkg::instr_t     prog_wdata;
	logic [PC_W-1:0]     prog_raddr;
	pvm_pkg::instr_t     prog_rdata;

	logic                rng_we;
	logic [RI_W-1:0]     rng_waddr;
	pvm_pkg::range_t     rng_wdata;
	pvm_pkg::range_t     rng_rdata;

	logic                thr_we;
	logic [PC_W:0]       thr_waddr;
	logic [TW-1:0]       thr_wdata;
	logic [PC_W:0]       thr_raddr;
	logic [TW-1:0]       thr_rdata;
	logic [PC_W-1:0]     thr_rd_pc;
	slots_t              thr_rd_slots;

	logic                stk_we;
	logic [TW-1:0]       stk_wdata;
	logic [PC_W-1:0]     stk_raddr;
	logic [TW-1:0]       stk_rdata;
	logic [CNT_W-1:0]    sp_m1;

	// Constant wrap tables for 6-bit targets
	logic [PC_W-1:0]     wrap_a [64];
	logic [RI_W-1:0]     wrap_r [64];

	logic                accept;
	logic                eps_op;
	logic [PC_W-1:0]     tpc_inc;
	logic [PC_W-1:0]     cpc_inc;
	logic [RI_W-1:0]     ridx_inc;
	logic                range_hit;
	logic [31:0]         end32;
	logic [31:0]         best32;

	always_comb begin
		for (int i = 0; i < 64; i++) begin
			wrap_a[i] = PC_W'(i % PROG_DEPTH);
			wrap_r[i] = RI_W'(i % RANGE_DEPTH);
		end
	end

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign eps_op   = (prog_rdata.op == pvm_pkg::OP_JUMP) ||
	                  (prog_rdata.op == pvm_pkg::OP_SPLIT) ||
	                  (prog_rdata.op == pvm_pkg::OP_SAVE);
	assign tpc_inc  = (tpc_q == PC_W'(PROG_DEPTH - 1)) ? '0 : tpc_q + 1'b1;
	assign cpc_inc  = (cpc_q == PC_W'(PROG_DEPTH - 1)) ? '0 : cpc_q + 1'b1;
	assign ridx_inc = (ridx_q == RI_W'(RANGE_DEPTH - 1)) ? '0 : ridx_q + 1'b1;
	assign range_hit = (rng_rdata.lo <= ch_q) && (ch_q <= rng_rdata.hi);
	assign sp_m1    = sp_q - 1'b1;
	assign {thr_rd_pc, thr_rd_slots} = thr_rdata;
	assign end32    = 32'(end_q);
	assign best32   = 32'(best_q[rep_k_q]);

	// Memory port steering
	always_comb begin
		prog_we    = accept && (mode == pvm_pkg::MODE_INSTR) && (32'(address) < PROG_DEPTH);
		prog_waddr = PC_W'(address);
		prog_wdata = '{op: opcode, ch: char_value, ta: target_a, tb: target_b,
		               sc: slot_or_count};
		prog_raddr = (state_q == S_T_INS) ? thr_rd_pc : cpc_q;

		rng_we     = accept && (mode == pvm_pkg::MODE_RANGE) && (32'(address) < RANGE_DEPTH);
		rng_waddr  = RI_W'(address);
		rng_wdata  = '{hi: range_high, lo: char_value};

		thr_we     = (state_q == S_C_EXEC) && !eps_op && (n_next_q < CNT_W'(PROG_DEPTH));
		thr_waddr  = {~sel_q, n_next_q[PC_W-1:0]};
		thr_wdata  = {cpc_q, cslots_q};
		thr_raddr  = {sel_q, t_q[PC_W-1:0]};

		stk_we     = (state_q == S_C_EXEC) && (prog_rdata.op == pvm_pkg::OP_SPLIT);
		stk_wdata  = {wrap_a[{1'b0, prog_rdata.tb}], cslots_q};
		stk_raddr  = sp_m1[PC_W-1:0];
	end

	pvm_ram #(.DEPTH(PROG_DEPTH), .WIDTH($bits(pvm_pkg::instr_t))) u_prog (
		.clk(clk), .we(prog_we), .waddr(prog_waddr), .wdata(prog_wdata),
		.raddr(prog_raddr), .rdata(prog_rdata)
	);

	pvm_ram #(.DEPTH(RD_D), .WIDTH($bits(pvm_pkg::range_t))) u_range (
		.clk(clk), .we(rng_we), .waddr(rng_waddr), .wdata(rng_wdata),
		.raddr(ridx_q), .rdata(rng_rdata)
	);

	// Two thread lists, bank bit on top of the thread index
	pvm_ram #(.DEPTH(2 ** (PC_W + 1)), .WIDTH(TW)) u_threads (
		.clk(clk), .we(thr_we), .waddr(thr_waddr), .wdata(thr_wdata),
		.raddr(thr_raddr), .rdata(thr_rdata)
	);

	// Pending lower-priority Split branches with their capture copies
	pvm_ram #(.DEPTH(2 ** PC_W), .WIDTH(TW)) u_stack (
		.clk(clk), .we(stk_we), .waddr(sp_q[PC_W-1:0]), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			ret_text_q  <= 1'b0;
			visit_q     <= '0;
			sel_q       <= 1'b0;
			n_cur_q     <= '0;
			n_next_q    <= '0;
			t_q         <= '0;
			rcnt_q      <= '0;
			running_q   <= 1'b0;
			found_q     <= 1'b0;
			end_q       <= '0;
			position_q  <= '0;
			npos_q      <= '0;
			best_q      <= '0;
			rep_k_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Drop the result once taken; the report state reloads it
			if (out_valid_q && out_ready && state_q != S_REP) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && mode == pvm_pkg::MODE_START) begin
						best_q     <= '0;
						found_q    <= 1'b0;
						end_q      <= '0;
						position_q <= '0;
						npos_q     <= '0;
						sel_q      <= 1'b1;
						n_cur_q    <= '0;
						n_next_q   <= '0;
						running_q  <= 1'b1;
						visit_q    <= '0;
						sp_q       <= '0;
						cpc_q      <= '0;
						cslots_q   <= '0;
						cpos_q     <= '0;
						ret_text_q <= 1'b0;
						state_q    <= S_C_FETCH;
					end else if (accept && mode == pvm_pkg::MODE_TEXT && running_q) begin
						ch_q     <= char_value;
						npos_q   <= (position_q == POS_MAX) ? POS_MAX : position_q + 1'b1;
						n_next_q <= '0;
						visit_q  <= '0;
						t_q      <= '0;
						state_q  <= S_T_READ;
					end
				end
				S_C_FETCH: begin
					if (visit_q[cpc_q]) begin
						state_q <= S_C_POP;
					end else begin
						visit_q[cpc_q] <= 1'b1;
						state_q        <= S_C_EXEC;
					end
				end
				S_C_EXEC: begin
					case (prog_rdata.op)
						pvm_pkg::OP_JUMP: begin
							cpc_q   <= wrap_a[prog_rdata.ta];
							state_q <= S_C_FETCH;
						end
						pvm_pkg::OP_SPLIT: begin
							sp_q    <= sp_q + 1'b1;
							cpc_q   <= wrap_a[prog_rdata.ta];
							state_q <= S_C_FETCH;
						end
						pvm_pkg::OP_SAVE: begin
							if (32'(prog_rdata.sc) < NSAVE) begin
								cslots_q[prog_rdata.sc[SL_W-1:0]] <= cpos_q;
							end
							cpc_q   <= cpc_inc;
							state_q <= S_C_FETCH;
						end
						default: begin
							if (n_next_q < CNT_W'(PROG_DEPTH)) begin
								n_next_q <= n_next_q + 1'b1;
							end
							state_q <= S_C_POP;
						end
					endcase
				end
				S_C_POP: begin
					if (sp_q == '0) begin
						if (ret_text_q) begin
							t_q     <= t_q + 1'b1;
							state_q <= S_T_READ;
						end else begin
							state_q <= S_ROUND;
						end
					end else begin
						sp_q    <= sp_m1;
						state_q <= S_C_LOAD;
					end
				end
				S_C_LOAD: begin
					{cpc_q, cslots_q} <= stk_rdata;
					state_q           <= S_C_FETCH;
				end
				S_T_READ: begin
					state_q <= (t_q < n_cur_q) ? S_T_INS : S_ROUND;
				end
				S_T_INS: begin
					tpc_q    <= thr_rd_pc;
					tslots_q <= thr_rd_slots;
					state_q  <= S_T_EVAL;
				end
				S_T_EVAL: begin
					case (prog_rdata.op)
						pvm_pkg::OP_MATCH: begin
							// Record and drop every lower-priority thread
							best_q  <= tslots_q;
							found_q <= 1'b1;
							end_q   <= position_q;
							state_q <= S_ROUND;
						end
						pvm_pkg::OP_CHAR, pvm_pkg::OP_ANY: begin
							if (ch_q != 8'd0 && (prog_rdata.op == pvm_pkg::OP_ANY ||
							                     ch_q == prog_rdata.ch)) begin
								cpc_q      <= tpc_inc;
								cslots_q   <= tslots_q;
								cpos_q     <= npos_q;
								sp_q       <= '0;
								ret_text_q <= 1'b1;
								state_q    <= S_C_FETCH;
							end else begin
								t_q     <= t_q + 1'b1;
								state_q <= S_T_READ;
							end
						end
						pvm_pkg::OP_RANGE, pvm_pkg::OP_NRANGE: begin
							if (ch_q == 8'd0) begin
								t_q     <= t_q + 1'b1;
								state_q <= S_T_READ;
							end else begin
								ridx_q  <= wrap_r[prog_rdata.ta];
								rcnt_q  <= '0;
								rsc_q   <= prog_rdata.sc;
								rneg_q  <= (prog_rdata.op == pvm_pkg::OP_NRANGE);
								state_q <= S_R_READ;
							end
						end
						default: begin
							t_q     <= t_q + 1'b1;
							state_q <= S_T_READ;
						end
					endcase
				end
				S_R_READ, S_R_CMP: begin
					// Scan pairs one at a time; a hit or end of list decides
					if ((state_q == S_R_READ && rcnt_q == rsc_q) ||
					    (state_q == S_R_CMP && range_hit)) begin
						if ((state_q == S_R_CMP) != rneg_q) begin
							cpc_q      <= tpc_inc;
							cslots_q   <= tslots_q;
							cpos_q     <= npos_q;
							sp_q       <= '0;
							ret_text_q <= 1'b1;
							state_q    <= S_C_FETCH;
						end else begin
							t_q     <= t_q + 1'b1;
							state_q <= S_T_READ;
						end
					end else if (state_q == S_R_READ) begin
						state_q <= S_R_CMP;
					end else begin
						rcnt_q  <= rcnt_q + 1'b1;
						ridx_q  <= ridx_inc;
						state_q <= S_R_READ;
					end
				end
				S_ROUND: begin
					sel_q      <= ~sel_q;
					n_cur_q    <= n_next_q;
					position_q <= npos_q;
					if (n_next_q == '0) begin
						running_q <= 1'b0;
						rep_k_q   <= '0;
						state_q   <= S_REP;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_REP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						match_found_q <= found_q;
						match_end_q   <= found_q ? end32[15:0] : 16'd0;
						slot_index_q  <= 3'(rep_k_q);
						slot_value_q  <= found_q ? best32[15:0] : 16'd0;
						last_q        <= (rep_k_q == SL_W'(REP_N - 1));
						if (rep_k_q == SL_W'(REP_N - 1)) begin
							state_q <= S_IDLE;
						end else begin
							rep_k_q <= rep_k_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign match_found = match_found_q;
	assign match_end   = match_end_q;
	assign slot_index  = slot_index_q;
	assign slot_value  = slot_value_q;
	assign last        = last_q;

endmodule
`default_nettype wire

@@ bench/pike_vm_regex_matcher_test.sv @@
// Self-checking testbench for the Pike-VM regex matcher: random programs, text and handshakes.
`timescale 1ns / 100ps
module pike_vm_regex_matcher_test;

	typedef logic [7:0][15:0] slotvec_t;

	// One pending request as the driver presents it.
	typedef struct {
		logic [1:0] mode;
		logic [5:0] address;
		logic [2:0] opcode;
		logic [7:0] char_value;
		logic [7:0] range_high;
		logic [5:0] target_a;
		logic [4:0] target_b;
		logic [4:0] slot_or_count;
		bit         wait_idle;   // hold this request until no result is outstanding
	} request_t;

	// One expected report entry.
	typedef struct {
		logic        found;
		logic [15:0] end_pos;
		logic [2:0]  slot;
		logic [15:0] value;
		logic        is_last;
	} report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = pvm_pkg::MODE_INSTR;
	logic [5:0]  address = '0;
	logic [2:0]  opcode = pvm_pkg::OP_CHAR;
	logic [7:0]  char_value = '0;
	logic [7:0]  range_high = '0;
	logic [5:0]  target_a = '0;
	logic [4:0]  target_b = '0;
	logic [4:0]  slot_or_count = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        match_found;
	logic [15:0] match_end;
	logic [2:0]  slot_index;
	logic [15:0] slot_value;
	logic        last;

	pike_vm_regex_matcher i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .address(address), .opcode(opcode), .char_value(char_value),
		.range_high(range_high), .target_a(target_a), .target_b(target_b),
		.slot_or_count(slot_or_count),
		.out_valid(out_valid), .out_ready(out_ready),
		.match_found(match_found), .match_end(match_end), .slot_index(slot_index),
		.slot_value(slot_value), .last(last)
	);

	always #5 clk = ~clk;

	request_t pending_requests[$];
	report_t  expected_reports[$];
	int       errors = 0;
	int       accepted_requests = 0;
	int       checked_reports = 0;
	int       runs_matched = 0;
	int       runs_reported = 0;
	bit       req_taken = 1'b0;

	// ------------------------------------------------------------------
	// Matcher model: program, range pairs, thread lists and run state.
	// ------------------------------------------------------------------
	pvm_pkg::instr_t prog_mem[32];
	pvm_pkg::range_t pair_mem[64];
	bit       visited[32];
	int       live_n, spawn_n;
	int       live_pc[32], spawn_pc[32];
	slotvec_t live_slots[32], spawn_slots[32];
	slotvec_t best_captures;
	int       text_pos;
	bit       searching, matched;
	int       matched_end;

	// Walk the epsilon closure of pc, appending runnable threads in priority order.
	function automatic void spawn_closure(int pc, slotvec_t caps, int at);
		pvm_pkg::instr_t w;
		pc = pc % 32;
		if (visited[pc])
			return;
		visited[pc] = 1'b1;
		w = prog_mem[pc];
		case (w.op)
			pvm_pkg::OP_JUMP: begin
				spawn_closure(w.ta, caps, at);
			end
			pvm_pkg::OP_SPLIT: begin
				spawn_closure(w.ta, caps, at);
				spawn_closure(w.tb, caps, at);
			end
			pvm_pkg::OP_SAVE: begin
				if (w.sc < 8)
					caps[w.sc[2:0]] = at[15:0];
				spawn_closure(pc + 1, caps, at);
			end
			default: begin
				if (spawn_n < 32) begin
					spawn_pc[spawn_n] = pc;
					spawn_slots[spawn_n] = caps;
					spawn_n++;
				end
			end
		endcase
	endfunction

	function automatic bit byte_in_pairs(pvm_pkg::instr_t w, logic [7:0] b);
		bit hit = 1'b0;
		int idx;
		if (b == 8'd0)
			return 1'b0;
		for (int i = 0; i < w.sc; i++) begin
			idx = (w.ta + i) % 64;
			if (pair_mem[idx].lo <= b && b <= pair_mem[idx].hi) begin
				hit = 1'b1;
				break;
			end
		end
		return (w.op == pvm_pkg::OP_RANGE) ? hit : !hit;
	endfunction

	function automatic void queue_report();
		report_t r;
		for (int k = 0; k < 8; k++) begin
			r.found   = matched;
			r.end_pos = matched ? matched_end[15:0] : 16'd0;
			r.slot    = k[2:0];
			r.value   = matched ? best_captures[k] : 16'd0;
			r.is_last = (k == 7);
			expected_reports.push_back(r);
		end
		runs_reported++;
		if (matched)
			runs_matched++;
		searching = 1'b0;
	endfunction

	function automatic void adopt_spawned();
		live_n = spawn_n;
		for (int i = 0; i < spawn_n; i++) begin
			live_pc[i] = spawn_pc[i];
			live_slots[i] = spawn_slots[i];
		end
	endfunction

	// Apply one accepted request to the model and queue the results it causes.
	function automatic void predict_request(request_t q);
		pvm_pkg::instr_t w;
		bit       adv;
		int       npos;
		case (q.mode)
			pvm_pkg::MODE_INSTR: begin
				if (q.address < 32)
					prog_mem[q.address] = '{op: q.opcode, ch: q.char_value, ta: q.target_a,
						tb: q.target_b, sc: q.slot_or_count};
			end
			pvm_pkg::MODE_RANGE: begin
				pair_mem[q.address] = '{hi: q.range_high, lo: q.char_value};
			end
			pvm_pkg::MODE_START: begin
				best_captures = '0;
				visited = '{default: 1'b0};
				matched = 1'b0;
				matched_end = 0;
				text_pos = 0;
				searching = 1'b1;
				spawn_n = 0;
				spawn_closure(0, '0, 0);
				adopt_spawned();
				if (live_n == 0)
					queue_report();
			end
			default: begin
				if (searching) begin
					npos = (text_pos < 65535) ? text_pos + 1 : 65535;
					spawn_n = 0;
					visited = '{default: 1'b0};
					for (int t = 0; t < live_n; t++) begin
						w = prog_mem[live_pc[t]];
						if (w.op == pvm_pkg::OP_MATCH) begin
							best_captures = live_slots[t];
							matched = 1'b1;
							matched_end = text_pos;
							break;
						end
						adv = 1'b0;
						if (w.op == pvm_pkg::OP_CHAR)
							adv = (q.char_value != 0 && q.char_value == w.ch);
						else if (w.op == pvm_pkg::OP_ANY)
							adv = (q.char_value != 0);
						else if (w.op == pvm_pkg::OP_RANGE || w.op == pvm_pkg::OP_NRANGE)
							adv = byte_in_pairs(w, q.char_value);
						if (adv)
							spawn_closure(live_pc[t] + 1, live_slots[t], npos);
					end
					text_pos = npos;
					adopt_spawned();
					if (live_n == 0)
						queue_report();
				end
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------
	function automatic void add_request(int m, int a, int op, int ch, int rh, int ta, int tb,
			int sc, bit hold = 1'b0);
		pending_requests.push_back('{2'(m), 6'(a), 3'(op), 8'(ch), 8'(rh), 6'(ta), 5'(tb),
			5'(sc), hold});
	endfunction

	// Text byte: other fields carry noise, the block must ignore them.
	function automatic void add_text(logic [7:0] b);
		add_request(pvm_pkg::MODE_TEXT, $urandom, $urandom, b, $urandom, $urandom, $urandom,
			$urandom);
	endfunction

	function automatic logic [7:0] pick_letter();
		return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
			: 8'($urandom_range(8'h61, 8'h64));
	endfunction

	// Random program of len instructions, always ending in a Match.
	function automatic void add_program(int len);
		int          w;
		logic [2:0]  op;
		logic [5:0]  ta;
		logic [4:0]  tb;
		logic [4:0]  sc;
		for (int i = 0; i < len; i++) begin
			w = $urandom_range(0, 99);
			if (w < 30)      op = pvm_pkg::OP_CHAR;
			else if (w < 40) op = pvm_pkg::OP_ANY;
			else if (w < 50) op = pvm_pkg::OP_RANGE;
			else if (w < 55) op = pvm_pkg::OP_NRANGE;
			else if (w < 62) op = pvm_pkg::OP_MATCH;
			else if (w < 70) op = pvm_pkg::OP_JUMP;
			else if (w < 85) op = pvm_pkg::OP_SPLIT;
			else             op = pvm_pkg::OP_SAVE;
			if (i == len - 1)
				op = pvm_pkg::OP_MATCH;
			ta = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, len - 1));
			tb = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, len - 1));
			if (op == pvm_pkg::OP_RANGE || op == pvm_pkg::OP_NRANGE)
				ta = 6'($urandom_range(0, 7));
			if (op == pvm_pkg::OP_SAVE)
				sc = ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
			else if (op == pvm_pkg::OP_RANGE || op == pvm_pkg::OP_NRANGE)
				sc = 5'($urandom_range(0, 4));
			else
				sc = 5'($urandom);
			add_request(pvm_pkg::MODE_INSTR, i, op, pick_letter(), $urandom, ta, tb, sc);
		end
	endfunction

	// ------------------------------------------------------------------
	// Driver: bursts of requests with random gaps, changes at falling edges.
	// ------------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		if (arst_n && (!in_valid || req_taken)) begin
			req_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_requests.size() == 0 ||
					(pending_requests[0].wait_idle && expected_reports.size() != 0)) begin
				in_valid <= 1'b0;
			end else begin
				request_t q;
				q = pending_requests.pop_front();
				in_valid      <= 1'b1;
				mode          <= q.mode;
				address       <= q.address;
				opcode        <= q.opcode;
				char_value    <= q.char_value;
				range_high    <= q.range_high;
				target_a      <= q.target_a;
				target_b      <= q.target_b;
				slot_or_count <= q.slot_or_count;
				if (burst_left > 0)
					burst_left--;
				else begin
					// Start a new burst; a third of them run without any gap.
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
	end

	// Receiver: stall pattern switches among always-ready, coin toss and sparse.
	int stall_style = 0;
	int stall_age = 0;
	always @(negedge clk) begin
		stall_age++;
		if (stall_age > 150) begin
			stall_age = 0;
			stall_style = $urandom_range(0, 2);
		end
		case (stall_style)
			0:       out_ready <= 1'b1;
			1:       out_ready <= $urandom_range(0, 1);
			default: out_ready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	// Monitor: take requests into the model, check reports against the oldest expectation.
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			request_t q;
			q = '{mode, address, opcode, char_value, range_high, target_a, target_b,
				slot_or_count, 1'b0};
			predict_request(q);
			accepted_requests++;
			req_taken = 1'b1;
		end
		if (out_valid && out_ready) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected result: slot_index %0d slot_value %0d", slot_index,
					slot_value);
				errors++;
			end else begin
				report_t r;
				r = expected_reports.pop_front();
				checked_reports++;
				if (match_found !== r.found) begin
					$error("match_found: expected %0d, got %0d", r.found, match_found);
					errors++;
				end
				if (match_end !== r.end_pos) begin
					$error("match_end: expected %0d, got %0d", r.end_pos, match_end);
					errors++;
				end
				if (slot_index !== r.slot) begin
					$error("slot_index: expected %0d, got %0d", r.slot, slot_index);
					errors++;
				end
				if (slot_value !== r.value) begin
					$error("slot_value: expected %0d, got %0d", r.value, slot_value);
					errors++;
				end
				if (last !== r.is_last) begin
					$error("last: expected %0d, got %0d", r.is_last, last);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin
		int random_items;
		int len;
		int nbytes;
		searching = 1'b0;
		matched = 1'b0;
		live_n = 0;

		// Fill both stores so no run ever fetches an unwritten entry.
		for (int i = 0; i < 32; i++)
			add_request(pvm_pkg::MODE_INSTR, i, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom);
		for (int i = 0; i < 64; i++)
			add_request(pvm_pkg::MODE_RANGE, i, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom);

		// Directed: captures, every opcode, wrap of range base, ignored slot and address.
		add_request(pvm_pkg::MODE_RANGE, 0, pvm_pkg::OP_CHAR, 8'h62, 8'h64, 0, 0, 0);
		add_request(pvm_pkg::MODE_RANGE, 63, pvm_pkg::OP_CHAR, 8'h01, 8'hff, 0, 0, 0);
		add_request(pvm_pkg::MODE_RANGE, 1, pvm_pkg::OP_CHAR, 8'h00, 8'h00, 0, 0, 0);
		add_request(pvm_pkg::MODE_INSTR, 0, pvm_pkg::OP_SAVE, 0, 0, 0, 0, 0);
		add_request(pvm_pkg::MODE_INSTR, 1, pvm_pkg::OP_CHAR, 8'h61, 0, 0, 0, 0);
		add_request(pvm_pkg::MODE_INSTR, 2, pvm_pkg::OP_RANGE, 0, 0, 0, 0, 1);
		add_request(pvm_pkg::MODE_INSTR, 3, pvm_pkg::OP_NRANGE, 0, 0, 6'd63, 0, 5'd2);
		add_request(pvm_pkg::MODE_INSTR, 4, pvm_pkg::OP_ANY, 8'hff, 8'hff, 6'd63, 5'd31, 5'd31);
		add_request(pvm_pkg::MODE_INSTR, 5, pvm_pkg::OP_SPLIT, 0, 0, 6'd38, 5'd1, 0);
		add_request(pvm_pkg::MODE_INSTR, 6, pvm_pkg::OP_SAVE, 0, 0, 0, 0, 5'd9);
		add_request(pvm_pkg::MODE_INSTR, 7, pvm_pkg::OP_SAVE, 0, 0, 0, 0, 5'd7);
		add_request(pvm_pkg::MODE_INSTR, 8, pvm_pkg::OP_JUMP, 0, 0, 6'd41, 0, 0);
		add_request(pvm_pkg::MODE_INSTR, 9, pvm_pkg::OP_MATCH, 0, 0, 0, 0, 0);
		// Dropped: beyond the program store.
		add_request(pvm_pkg::MODE_INSTR, 6'd40, pvm_pkg::OP_MATCH, 0, 0, 0, 0, 0);
		add_text(8'h61);                                       // idle: ignored
		add_request(pvm_pkg::MODE_START, 0, 0, 0, 0, 0, 0, 0);
		add_text(8'h61);
		add_request(pvm_pkg::MODE_START, 0, 0, 0, 0, 0, 0, 0);  // abandon and restart
		add_text(8'h61); add_text(8'h63); add_text(8'hff); add_text(8'h00);
		// Start whose closure is empty reports on the start itself.
		add_request(pvm_pkg::MODE_INSTR, 0, pvm_pkg::OP_JUMP, 0, 0, 0, 0, 0, 1'b1);
		add_request(pvm_pkg::MODE_START, 0, 0, 0, 0, 0, 0, 0);

		// Random: mostly well-formed runs, some noise and broken runs.
		random_items = 0;
		while (random_items < 190) begin
			int before_n;
			before_n = pending_requests.size();
			if ($urandom_range(0, 3) == 0)
				for (int i = 0; i < 3; i++)
					add_request(pvm_pkg::MODE_RANGE, $urandom_range(0, 7), $urandom,
						pick_letter(), pick_letter(), $urandom, $urandom, $urandom);
			len = $urandom_range(2, 10);
			add_program(len);
			add_request(pvm_pkg::MODE_START, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom_range(0, 9) == 0);
			nbytes = $urandom_range(0, 10);
			for (int i = 0; i < nbytes; i++)
				add_text(pick_letter());
			if ($urandom_range(0, 5) != 0)
				add_text(8'h00);
			if ($urandom_range(0, 4) == 0)
				add_text(pick_letter());
			random_items += pending_requests.size() - before_n;
		end
		// Force the complete drain once more near the end.
		add_request(pvm_pkg::MODE_START, 0, 0, 0, 0, 0, 0, 0, 1'b1);
		add_text(8'h00);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_requests.size() != 0 || in_valid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (expected_reports.size() != 0) begin
			$error("%0d expected results never arrived", expected_reports.size());
			errors++;
		end
		$display("Covered %0d requests, %0d reports (%0d with a match), %0d results checked.",
			accepted_requests, runs_reported, runs_matched, checked_reports);
		if (errors == 0)
			$display("[pike_vm_regex_matcher] OK");
		else
			$display("[pike_vm_regex_matcher] ERROR");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#50ms;
		$display("[pike_vm_regex_matcher] ERROR");
		$finish;
	end

endmodule
